FILE: hdl/hcenc_pkg.sv
// Package for the Hill cipher encryptor: shared constants, input action codes,
// queue job kinds and the small mod-26 reduction.
// No dependencies.
package hcenc_pkg;

    localparam int MAX_BLOCK_DEF = 9;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [3:0] BLOCK_SIZE_RST = 4'd2;
    localparam logic [4:0] ALPHABET       = 5'd26;
    localparam logic [4:0] PAD_VALUE      = 5'd23;   // 'x'
    localparam logic [6:0] LETTER_BASE    = 7'd97;   // 'a'
    localparam logic [7:0] UPPER_A        = 8'd65;
    localparam logic [7:0] UPPER_Z        = 8'd90;
    localparam logic [7:0] LOWER_A        = 8'd97;
    localparam logic [7:0] LOWER_Z        = 8'd122;

    localparam logic [1:0] ACT_KEY   = 2'd0;
    localparam logic [1:0] ACT_TEXT  = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    localparam logic JOB_KEY   = 1'b0;
    localparam logic JOB_BLOCK = 1'b1;

    // Reduce a value below 832 to 0..25 by conditional subtraction of 26 * 2^k.
    function automatic logic [4:0] mod26(input logic [9:0] x);
        logic [9:0] r;
        r = x;
        if (r >= 10'd416) r = r - 10'd416;
        if (r >= 10'd208) r = r - 10'd208;
        if (r >= 10'd104) r = r - 10'd104;
        if (r >= 10'd52)  r = r - 10'd52;
        if (r >= 10'd26)  r = r - 10'd26;
        return r[4:0];
    endfunction

endpackage

FILE: hdl/hill_cipher_encryptor.sv
// Streaming Hill cipher encryptor, mod 26.
// Input channel (i_in_valid / o_in_ready) takes one word per handshake: a key
// entry write, a text byte or an end-of-text flush. Non-letters are dropped,
// letters fold to lower case and gather in a block of block_size letters.
// Output channel (o_out_valid / i_out_ready) gives one cipher letter per word,
// block_last high on the final letter of each block.
// block_size is written through i_cfg_we / i_cfg_data; the user must write it
// only while the block is idle, which the block itself leaves unchecked. The
// front end takes any word, also a letter that completes a block, whenever the
// two-entry queue has room. The back end retires a key write straight from
// the queue; for a block of n letters each cipher letter needs n key reads
// through the key store's single read port, then the multiply and mod-26
// stages, and no further job leaves the queue until the block is done.
// Reset: block size 2, buffer fill zero, queue empty, output empty. The key
// store is not cleared; every key entry must be written before it is used.
// A stalled receiver holds the output register, then the back end, then the
// queue, and finally o_in_ready drops.
module hill_cipher_encryptor import hcenc_pkg::*; #(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [3:0] i_key_row,
    input  logic [3:0] i_key_col,
    input  logic [4:0] i_key_value,
    input  logic [7:0] i_text_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_cipher_letter,
    output logic       o_block_last
);

    localparam int PW = 1 + $clog2(MAX_BLOCK * MAX_BLOCK) + 5
                        + $clog2(MAX_BLOCK + 1) + 5 * MAX_BLOCK;

    logic [3:0]    r_block_size;
    logic          push, full, pop, empty;
    logic [PW-1:0] push_job, head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BLOCK_SIZE_RST;
        end else if (i_cfg_we) begin
            r_block_size <= i_cfg_data;
        end
    end

    hcenc_front #(
        .MAX_BLOCK (MAX_BLOCK),
        .PW        (PW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_block_size (r_block_size),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_key_row    (i_key_row),
        .i_key_col    (i_key_col),
        .i_key_value  (i_key_value),
        .i_text_byte  (i_text_byte),
        .o_push       (push),
        .o_job        (push_job),
        .i_full       (full)
    );

    hcenc_fifo #(
        .WIDTH (PW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_empty (empty)
    );

    hcenc_back #(
        .MAX_BLOCK (MAX_BLOCK),
        .PW        (PW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (!empty),
        .i_job           (head_job),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cipher_letter (o_cipher_letter),
        .o_block_last    (o_block_last)
    );

endmodule

FILE: hdl/hcenc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hcenc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 81
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/hcenc_fifo.sv
// Short job queue between the front and back ends of the encryptor.
// Depends on nothing but its parameters.
module hcenc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTRW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTRW-1:0]  r_wptr, r_rptr;
    logic [CNTW-1:0]  r_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    function automatic logic [PTRW-1:0] ptr_inc(input logic [PTRW-1:0] p);
        return (p == PTRW'(DEPTH - 1)) ? '0 : p + PTRW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) r_wptr <= ptr_inc(r_wptr);
            if (pop_ok)  r_rptr <= ptr_inc(r_rptr);
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CNTW'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

FILE: hdl/hcenc_front.sv
// Front end: accepts input words, filters and folds letters into the block
// buffer and queues key writes and complete blocks. Uses hcenc_pkg.
module hcenc_front import hcenc_pkg::*; #(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF,
    parameter int PW        = 1 + $clog2(MAX_BLOCK * MAX_BLOCK) + 5
                              + $clog2(MAX_BLOCK + 1) + 5 * MAX_BLOCK
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [3:0]    i_block_size,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_action,
    input  logic [3:0]    i_key_row,
    input  logic [3:0]    i_key_col,
    input  logic [4:0]    i_key_value,
    input  logic [7:0]    i_text_byte,
    output logic          o_push,
    output logic [PW-1:0] o_job,
    input  logic          i_full
);

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int IW    = $clog2(MAX_BLOCK);
    localparam int AW    = $clog2(MAX_BLOCK * MAX_BLOCK);
    localparam int BW    = 5 * MAX_BLOCK;

    logic [4:0]       r_buf [MAX_BLOCK];
    logic [CNT_W-1:0] r_fill, n_fill;

    logic             accept, is_letter, key_ok, fill_room;
    logic [CNT_W-1:0] eff_n, fill_inc;
    logic [4:0]       letter_val, key_val;
    logic [AW-1:0]    key_addr;
    logic [BW-1:0]    blk_text, blk_flush;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        // clamp the block size to 2..MAX_BLOCK
        if (i_block_size < 4'd2) begin
            eff_n = CNT_W'(2);
        end else if (32'(i_block_size) > 32'(MAX_BLOCK)) begin
            eff_n = CNT_W'(MAX_BLOCK);
        end else begin
            eff_n = CNT_W'(i_block_size);
        end

        is_letter  = 1'b1;
        letter_val = '0;
        if (i_text_byte >= UPPER_A && i_text_byte <= UPPER_Z) begin
            letter_val = 5'(i_text_byte - UPPER_A);
        end else if (i_text_byte >= LOWER_A && i_text_byte <= LOWER_Z) begin
            letter_val = 5'(i_text_byte - LOWER_A);
        end else begin
            is_letter = 1'b0;
        end

        key_ok   = (32'(i_key_row) < 32'(MAX_BLOCK)) && (32'(i_key_col) < 32'(MAX_BLOCK));
        key_addr = AW'(32'(i_key_row) * 32'(MAX_BLOCK) + 32'(i_key_col));
        key_val  = (i_key_value >= ALPHABET) ? i_key_value - ALPHABET : i_key_value;

        fill_room = 32'(r_fill) < 32'(MAX_BLOCK);
        fill_inc  = fill_room ? r_fill + CNT_W'(1) : r_fill;

        for (int k = 0; k < MAX_BLOCK; k++) begin
            blk_text[5*k +: 5]  = (fill_room && k == int'(r_fill)) ? letter_val : r_buf[k];
            blk_flush[5*k +: 5] = (k < int'(r_fill)) ? r_buf[k] : PAD_VALUE;
        end

        o_push = 1'b0;
        o_job  = {JOB_KEY, key_addr, key_val, CNT_W'(0), BW'(0)};
        n_fill = r_fill;
        if (accept) begin
            case (i_action)
                ACT_KEY: begin
                    o_push = key_ok;
                end
                ACT_TEXT: begin
                    if (is_letter) begin
                        n_fill = fill_inc;
                        if (fill_inc >= eff_n) begin
                            o_push = 1'b1;
                            o_job  = {JOB_BLOCK, AW'(0), 5'd0, eff_n, blk_text};
                            n_fill = '0;
                        end
                    end
                end
                ACT_FLUSH: begin
                    if (r_fill != '0) begin
                        o_push = 1'b1;
                        o_job  = {JOB_BLOCK, AW'(0), 5'd0, eff_n, blk_flush};
                        n_fill = '0;
                    end
                end
                default: begin
                    // unused action: drop
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_action == ACT_TEXT && is_letter && fill_room) begin
            r_buf[r_fill[IW-1:0]] <= letter_val;
        end
    end

endmodule

FILE: hdl/hcenc_back.sv
// Back end: retires queued key writes into the key store and encrypts queued
// blocks row by row. Uses hcenc_pkg and hcenc_ram.
module hcenc_back import hcenc_pkg::*; #(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF,
    parameter int PW        = 1 + $clog2(MAX_BLOCK * MAX_BLOCK) + 5
                              + $clog2(MAX_BLOCK + 1) + 5 * MAX_BLOCK
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  logic [PW-1:0] i_job,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [6:0]    o_cipher_letter,
    output logic          o_block_last
);

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int IW    = $clog2(MAX_BLOCK);
    localparam int AW    = $clog2(MAX_BLOCK * MAX_BLOCK);
    localparam int BW    = 5 * MAX_BLOCK;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ROW   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_n, r_i, r_j, r_j1;
    logic [AW-1:0]    r_base;
    logic [4:0]       r_blk [MAX_BLOCK];
    logic             r_v1, r_v2;
    logic [9:0]       r_prod;
    logic [4:0]       r_acc;
    logic             r_out_valid, r_last;
    logic [6:0]       r_letter;

    logic             job_kind;
    logic [AW-1:0]    job_addr;
    logic [4:0]       job_val;
    logic [CNT_W-1:0] job_n;
    logic             ram_we, ram_re, out_free, emit, row_end, last_row;
    logic [AW-1:0]    ram_raddr;
    logic [4:0]       ram_rdata;
    logic [9:0]       prod_c;

    assign job_kind = i_job[PW-1];
    assign job_addr = i_job[PW-2 -: AW];
    assign job_val  = i_job[PW-2-AW -: 5];
    assign job_n    = i_job[BW +: CNT_W];

    assign o_pop     = (r_state == S_IDLE) && i_job_valid;
    assign ram_we    = o_pop && (job_kind == JOB_KEY);
    assign ram_re    = (r_state == S_ROW);
    assign ram_raddr = r_base + AW'(r_j);
    assign out_free  = !r_out_valid || i_out_ready;
    // the row's sum is final once both pipeline stages are empty
    assign emit      = (r_state == S_DRAIN) && !r_v1 && !r_v2 && out_free;
    assign row_end   = (r_j == r_n - CNT_W'(1));
    assign last_row  = (r_i == r_n - CNT_W'(1));
    assign prod_c    = {5'd0, ram_rdata} * {5'd0, r_blk[r_j1[IW-1:0]]};

    hcenc_ram #(
        .WIDTH (5),
        .DEPTH (MAX_BLOCK * MAX_BLOCK)
    ) u_key_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (job_addr),
        .i_wdata (job_val),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= CNT_W'(2);
            r_i         <= '0;
            r_j         <= '0;
            r_base      <= '0;
            r_acc       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= ram_re;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_acc <= mod26(10'(r_acc) + r_prod);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && job_kind == JOB_BLOCK) begin
                        r_n     <= job_n;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_base  <= '0;
                        r_acc   <= '0;
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_j <= r_j + CNT_W'(1);
                    if (row_end) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (emit) begin
                        if (last_row) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + CNT_W'(1);
                            r_j     <= '0;
                            r_base  <= r_base + AW'(MAX_BLOCK);
                            r_acc   <= '0;
                            r_state <= S_ROW;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && job_kind == JOB_BLOCK) begin
            for (int k = 0; k < MAX_BLOCK; k++) begin
                r_blk[k] <= i_job[5*k +: 5];
            end
        end
        r_j1   <= r_j;
        r_prod <= prod_c;
        if (emit) begin
            r_letter <= 7'(r_acc) + LETTER_BASE;
            r_last   <= last_row;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cipher_letter = r_letter;
    assign o_block_last    = r_last;

endmodule

FILE: bench/hcenc_letter_checker.sv
// Cipher letter checker for the Hill cipher encryptor: follows both channels and
// the block size register, recomputes every cipher letter and compares in order.
// Depends on hcenc_pkg for the action codes and cipher constants.
`timescale 1ns / 1ps
module hcenc_letter_checker import hcenc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_action,
    input  logic [3:0] i_key_row,
    input  logic [3:0] i_key_col,
    input  logic [4:0] i_key_value,
    input  logic [7:0] i_text_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [6:0] i_cipher_letter,
    input  logic       i_block_last,
    output int         o_pending,
    output int         o_fail_count
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [6:0] letter;
        logic       last;
    } t_cipher_word;

    t_cipher_word cipher_due[$];
    logic [4:0]   key_grid [MAX_BLOCK_DEF][MAX_BLOCK_DEF];
    logic [4:0]   plain_block [MAX_BLOCK_DEF];
    int           plain_fill;
    logic [3:0]   block_size;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    function automatic int live_size();
        if (block_size < 4'd2)
            return 2;
        if (block_size > MAX_BLOCK_DEF)
            return MAX_BLOCK_DEF;
        return int'(block_size);
    endfunction

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP)
            $display("%0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    // Multiply the held block by the key, one cipher letter per key row.
    task automatic encipher_block(input int n);
        int           acc;
        t_cipher_word w;
        for (int i = 0; i < n; i++) begin
            acc = 0;
            for (int j = 0; j < n; j++)
                acc += int'(key_grid[i][j]) * int'(plain_block[j]);
            w.letter = LETTER_BASE + 7'(acc % int'(ALPHABET));
            w.last   = (i == n - 1);
            cipher_due.push_back(w);
        end
        plain_fill = 0;
    endtask

    task automatic absorb_word(input logic [1:0] act, input logic [3:0] row,
                               input logic [3:0] col, input logic [4:0] val,
                               input logic [7:0] text_in);
        int         n;
        logic       is_letter;
        logic [7:0] code;
        n         = live_size();
        is_letter = 1'b0;
        code      = '0;
        case (act)
            ACT_KEY: begin
                if (row < MAX_BLOCK_DEF && col < MAX_BLOCK_DEF)
                    key_grid[row][col] = val % ALPHABET;
            end
            ACT_TEXT: begin
                if (text_in >= UPPER_A && text_in <= UPPER_Z) begin
                    is_letter = 1'b1;
                    code      = text_in - UPPER_A;
                end else if (text_in >= LOWER_A && text_in <= LOWER_Z) begin
                    is_letter = 1'b1;
                    code      = text_in - LOWER_A;
                end
                if (is_letter) begin
                    if (plain_fill < MAX_BLOCK_DEF) begin
                        plain_block[plain_fill] = code[4:0];
                        plain_fill++;
                    end
                    // a shrunk block size can leave more letters held than n
                    if (plain_fill >= n)
                        encipher_block(n);
                end
            end
            ACT_FLUSH: begin
                if (plain_fill != 0) begin
                    for (int k = plain_fill; k < n; k++)
                        plain_block[k] = PAD_VALUE;
                    encipher_block(n);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_letter(input logic [6:0] letter, input logic last);
        t_cipher_word due;
        if (cipher_due.size() == 0) begin
            report_mismatch($sformatf("cipher letter %0d with none expected", letter));
        end else begin
            due = cipher_due.pop_front();
            if (letter !== due.letter)
                report_mismatch($sformatf("cipher_letter %0d, expected %0d",
                                          letter, due.letter));
            if (last !== due.last)
                report_mismatch($sformatf("block_last %0b, expected %0b",
                                          last, due.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cipher_due.delete();
            plain_fill = 0;
            block_size = BLOCK_SIZE_RST;
        end else begin
            // compare before predicting so a fresh word cannot cover a stray letter
            if (i_out_valid && i_out_ready)
                check_letter(i_cipher_letter, i_block_last);
            if (i_in_valid && i_in_ready)
                absorb_word(i_action, i_key_row, i_key_col, i_key_value, i_text_byte);
            // a new block size applies from the next word on
            if (i_cfg_we)
                block_size = i_cfg_data;
        end
        o_pending = cipher_due.size();
    end

endmodule

FILE: bench/hill_cipher_encryptor_test.sv
// Top of the Hill cipher encryptor bench: clock, reset, word stimulus with random
// gaps on both channels, block size phases and the verdict.
// Depends on hcenc_pkg, hill_cipher_encryptor and hcenc_letter_checker.
`timescale 1ns / 1ps
module hill_cipher_encryptor_test;
    import hcenc_pkg::*;

    localparam logic [1:0] ACT_SPARE    = 2'd3;
    localparam int         MAX_GAP      = 18;
    localparam int         DRAIN_CYCLES = 200;
    localparam int         IDLE_LIMIT   = 3000;
    localparam int         RANDOM_WORDS = 1;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [3:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] action;
    logic [3:0] key_row;
    logic [3:0] key_col;
    logic [4:0] key_value;
    logic [7:0] text_byte;
    logic       out_valid;
    logic       out_ready;
    logic [6:0] cipher_letter;
    logic       block_last;

    int         pending;
    int         fail_count;
    int         idle_run = 0;
    logic       tx_quiet = 1'b0;
    logic       rx_quiet = 1'b0;

    logic [3:0] size_plan [10] = '{4'd9, 4'd15, 4'd0, 4'd5, 4'd1,
                                   4'd12, 4'd3, 4'd7, 4'd4, 4'd2};

    hill_cipher_encryptor u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_action       (action),
        .i_key_row      (key_row),
        .i_key_col      (key_col),
        .i_key_value    (key_value),
        .i_text_byte    (text_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_cipher_letter(cipher_letter),
        .o_block_last   (block_last)
    );

    hcenc_letter_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_action       (action),
        .i_key_row      (key_row),
        .i_key_col      (key_col),
        .i_key_value    (key_value),
        .i_text_byte    (text_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_cipher_letter(cipher_letter),
        .i_block_last   (block_last),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hold the word until it is taken; called and left at a falling edge.
    task automatic send_word(input logic [1:0] act, input logic [3:0] row,
                             input logic [3:0] col, input logic [4:0] val,
                             input logic [7:0] text_in);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 29) == 0)
            tx_quiet = !tx_quiet;
        if (gap > 0)
            in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
        action    <= act;
        key_row   <= row;
        key_col   <= col;
        key_value <= val;
        text_byte <= text_in;
        in_valid  <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_key(input logic [3:0] row, input logic [3:0] col,
                            input logic [4:0] val);
        send_word(ACT_KEY, row, col, val, 8'($urandom));
    endtask

    task automatic send_text(input logic [7:0] text_in);
        send_word(ACT_TEXT, 4'($urandom), 4'($urandom), 5'($urandom), text_in);
    endtask

    task automatic send_flush();
        send_word(ACT_FLUSH, 4'($urandom), 4'($urandom), 5'($urandom), 8'($urandom));
    endtask

    function automatic logic [7:0] random_letter();
        return ($urandom_range(0, 1) ? LOWER_A : UPPER_A) + 8'($urandom_range(0, 25));
    endfunction

    // Mostly letters so blocks fill; the rest is noise, key rewrites and flushes.
    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            send_text(random_letter());
        else if (pick < 70)
            send_text(8'($urandom));
        else if (pick < 80)
            send_key(4'($urandom), 4'($urandom), 5'($urandom));
        else if (pick < 90)
            send_flush();
        else
            send_word(ACT_SPARE, 4'($urandom), 4'($urandom), 5'($urandom), 8'($urandom));
    endtask

    // Drain every expected letter, then let key writes still in the queue retire.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial begin
        int n_live;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        action    = ACT_KEY;
        key_row   = '0;
        key_col   = '0;
        key_value = '0;
        text_byte = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every entry must hold a value before any block reads the key
        for (int r = 0; r < MAX_BLOCK_DEF; r++)
            for (int c = 0; c < MAX_BLOCK_DEF; c++)
                send_key(4'(r), 4'(c), 5'($urandom_range(0, 31)));

        send_key(4'd15, 4'd0, 5'd31);
        send_key(4'd3, 4'd9, 5'd7);
        send_key(4'd0, 4'd0, 5'd31);
        send_key(4'd1, 4'd1, 5'd0);
        send_key(4'd8, 4'd8, 5'd26);
        send_text(UPPER_A);
        send_text(UPPER_Z);
        send_text(LOWER_A);
        send_text(LOWER_Z);
        send_text(8'd0);
        send_text(8'd255);
        send_text(UPPER_A - 8'd1);
        send_text(UPPER_Z + 8'd1);
        send_text(LOWER_A - 8'd1);
        send_text(LOWER_Z + 8'd1);
        send_word(ACT_SPARE, 4'd15, 4'd15, 5'd31, 8'd255);
        send_flush();
        send_text(LOWER_A + 8'd12);
        send_flush();
        send_flush();

        foreach (size_plan[p]) begin
            settle();
            cfg_we   <= 1'b1;
            cfg_data <= size_plan[p];
            @(negedge clk);
            cfg_we <= 1'b0;
            n_live = (size_plan[p] < 4'd2) ? 2 :
                     (size_plan[p] > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : int'(size_plan[p]);
            // the first word meets whatever partial block the last phase left
            if (p % 4 == 0)
                send_flush();
            else
                send_text(random_letter());
            repeat (RANDOM_WORDS) random_word();
            // leave the longest partial block for the next size to trip over
            send_flush();
            repeat (n_live - 1) send_text(random_letter());
        end
        send_flush();
        settle();

        if (fail_count == 0)
            $display("hill_cipher_encryptor verification clean");
        else
            $display("hill_cipher_encryptor verification failed");
        $finish;
    end

    initial begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 29) == 0)
                rx_quiet = !rx_quiet;
            if (stall > 0)
                out_ready <= 1'b0;
            repeat (stall) @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_run <= 0;
        end else if (idle_run == IDLE_LIMIT) begin
            $display("hill_cipher_encryptor verification failed");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

endmodule
